// ===== sv/ihrp_pkg.sv =====
package ihrp_pkg;

	localparam int unsigned PATCH_SLOTS = 14;
	localparam int unsigned HEADER_END = 8;
	localparam int unsigned MIN_LINE_LEN = 11;
	localparam int unsigned POS_W = 10;
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_MISMATCH = 2'd1,
		STAT_FORMAT   = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CFG_PATCH_FIRST  = 2'd0,
		CFG_PATCH_SECOND = 2'd1,
		CFG_WINDOW_BASE  = 2'd2,
		CFG_WINDOW_COUNT = 2'd3
	} cfg_index_t;

	typedef struct packed {
		logic [55:0] patch_first;
		logic [55:0] patch_second;
		logic [15:0] window_base;
		logic [3:0]  window_count;
	} cfg_t;

	typedef struct packed {
		logic [7:0]       ch;
		logic             last;
		logic [POS_W-1:0] pos;
		logic [3:0]       nib;
		logic             nib_ok;
	} entry_t;

	function automatic logic [7:0] template_byte(input logic [3:0] idx);
		logic [7:0] b;
		case (idx)
			4'd0:    b = 8'h01;
			4'd1:    b = 8'h23;
			4'd2:    b = 8'h45;
			4'd3:    b = 8'h67;
			4'd4:    b = 8'h89;
			4'd5:    b = 8'hAB;
			4'd6:    b = 8'hCD;
			4'd7:    b = 8'hEF;
			4'd8:    b = 8'h11;
			4'd9:    b = 8'h33;
			4'd10:   b = 8'h55;
			4'd11:   b = 8'h77;
			4'd12:   b = 8'h99;
			4'd13:   b = 8'hBB;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	function automatic logic [7:0] upper_hex(input logic [3:0] v);
		logic [7:0] c;
		if (v < 4'd10) begin
			c = 8'h30 + {4'd0, v};
		end else begin
			c = 8'h37 + {4'd0, v};
		end
		return c;
	endfunction

	function automatic logic [7:0] replacement(input cfg_t cfg, input logic [3:0] idx);
		logic [7:0] b;
		case (idx)
			4'd0:    b = cfg.patch_first[7:0];
			4'd1:    b = cfg.patch_first[15:8];
			4'd2:    b = cfg.patch_first[23:16];
			4'd3:    b = cfg.patch_first[31:24];
			4'd4:    b = cfg.patch_first[39:32];
			4'd5:    b = cfg.patch_first[47:40];
			4'd6:    b = cfg.patch_first[55:48];
			4'd7:    b = cfg.patch_second[7:0];
			4'd8:    b = cfg.patch_second[15:8];
			4'd9:    b = cfg.patch_second[23:16];
			4'd10:   b = cfg.patch_second[31:24];
			4'd11:   b = cfg.patch_second[39:32];
			4'd12:   b = cfg.patch_second[47:40];
			4'd13:   b = cfg.patch_second[55:48];
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

// ===== sv/ihrp_front.sv =====
module ihrp_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [7:0]          s_tdata,
	input  logic                s_tlast,
	input  logic                q_full,
	output logic                push,
	output ihrp_pkg::entry_t    push_entry
);

	logic [ihrp_pkg::POS_W-1:0] pos_q;
	logic [3:0]                 nib;
	logic                       nib_ok;

	always_comb begin
		nib = 4'd0;
		nib_ok = 1'b1;
		if (s_tdata >= 8'h30 && s_tdata <= 8'h39) begin
			nib = s_tdata[3:0];
		end else if ((s_tdata >= 8'h41 && s_tdata <= 8'h46) ||
				(s_tdata >= 8'h61 && s_tdata <= 8'h66)) begin
			nib = s_tdata[3:0] + 4'd9;
		end else begin
			nib_ok = 1'b0;
		end
	end

	assign s_tready = !q_full;
	assign push = s_tvalid && s_tready;

	always_comb begin
		push_entry.ch = s_tdata;
		push_entry.last = s_tlast;
		push_entry.pos = pos_q;
		push_entry.nib = nib;
		push_entry.nib_ok = nib_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (push) begin
			if (s_tlast) begin
				pos_q <= '0;
			end else if (pos_q != ihrp_pkg::POS_MAX) begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

endmodule

// ===== sv/ihrp_queue.sv =====
module ihrp_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  ihrp_pkg::entry_t push_entry,
	input  logic             pop,
	output ihrp_pkg::entry_t pop_entry,
	output logic             full,
	output logic             not_empty
);

	ihrp_pkg::entry_t mem_q [ihrp_pkg::QUEUE_DEPTH];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;

	assign full = (cnt_q == 2'(ihrp_pkg::QUEUE_DEPTH));
	assign not_empty = (cnt_q != 2'd0);
	assign pop_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

// ===== sv/ihrp_back.sv =====
module ihrp_back (
	input  logic             clk,
	input  logic             arst_n,
	input  ihrp_pkg::cfg_t   cfg,
	input  logic             q_not_empty,
	input  ihrp_pkg::entry_t e,
	output logic             pop,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [15:0]      m_tdata,
	output logic             m_tlast,
	output logic             m_tuser
);

	logic [7:0]  count_q, count_n;
	logic [15:0] addr_q, addr_n;
	logic [7:0]  sum_q, sum_n;
	logic [3:0]  hi_q, hi_n;
	logic [7:0]  seen_q, seen_n;
	logic        is_data_q, is_data_n;
	logic        ferr_q, ferr_n;
	logic        mism_q, mism_n;
	logic [3:0]  pcnt_q, pcnt_n;
	logic [1:0]  cs_q, cs_n;

	logic        valid_q;
	logic [7:0]  ch_q;
	logic        kept_q;
	logic        last_q;
	logic [1:0]  status_q;
	logic [3:0]  repl_q;

	logic [7:0]  ch;
	logic        kept;
	logic [1:0]  status;
	logic [3:0]  repl;
	logic [7:0]  b;
	logic [7:0]  cs;
	logic [3:0]  wcnt;
	logic [16:0] wend;
	logic [15:0] diff;
	logic        win;
	logic [3:0]  idx;
	logic [7:0]  r;

	assign pop = q_not_empty && (!valid_q || m_tready);

	always_comb begin
		wcnt = (cfg.window_count > 4'(ihrp_pkg::PATCH_SLOTS)) ?
			4'(ihrp_pkg::PATCH_SLOTS) : cfg.window_count;
		wend = {1'b0, cfg.window_base} + {12'd0, wcnt, 1'b0};
		diff = addr_q - cfg.window_base;
		win = (addr_q >= cfg.window_base) && ({1'b0, addr_q} < wend) && !diff[0];
		idx = diff[4:1];
		r = ihrp_pkg::replacement(cfg, idx);
	end

	always_comb begin
		count_n = count_q;
		addr_n = addr_q;
		sum_n = sum_q;
		hi_n = hi_q;
		seen_n = seen_q;
		is_data_n = is_data_q;
		ferr_n = ferr_q;
		mism_n = mism_q;
		pcnt_n = pcnt_q;
		cs_n = cs_q;
		ch = e.ch;
		kept = 1'b1;
		status = ihrp_pkg::STAT_OK;
		repl = 4'd0;
		b = {hi_q, e.nib};
		cs = 8'd0 - sum_q;

		if (e.pos == '0) begin
			if (e.ch != 8'h3A) begin
				ferr_n = 1'b1;
			end
		end else if (e.pos <= 10'(ihrp_pkg::HEADER_END)) begin
			if (!e.nib_ok) begin
				ferr_n = 1'b1;
			end
			if (e.pos[0]) begin
				hi_n = e.nib;
			end else begin
				sum_n = sum_q + b;
				case (e.pos[3:1])
					3'd1: count_n = b;
					3'd2: addr_n[15:8] = b;
					3'd3: addr_n[7:0] = b;
					default: begin
						if (!ferr_n && b == 8'd0) begin
							is_data_n = 1'b1;
						end
					end
				endcase
			end
		end else if (is_data_q) begin
			if (seen_q < count_q) begin
				if (!e.nib_ok) begin
					ferr_n = 1'b1;
				end
				if (e.pos[0]) begin
					hi_n = e.nib;
					if (win) begin
						ch = ihrp_pkg::upper_hex(r[7:4]);
					end
				end else begin
					if (win) begin
						if (b != ihrp_pkg::template_byte(idx)) begin
							mism_n = 1'b1;
						end
						ch = ihrp_pkg::upper_hex(r[3:0]);
						sum_n = sum_q + r;
						if (pcnt_q != 4'hF) begin
							pcnt_n = pcnt_q + 4'd1;
						end
					end else begin
						sum_n = sum_q + b;
					end
					seen_n = seen_q + 8'd1;
					addr_n = addr_q + 16'd1;
				end
			end else if (cs_q < 2'd2) begin
				ch = ihrp_pkg::upper_hex((cs_q == 2'd0) ? cs[7:4] : cs[3:0]);
				cs_n = cs_q + 2'd1;
			end else begin
				kept = 1'b0;
			end
		end

		if (e.last) begin
			if (e.pos < 10'(ihrp_pkg::MIN_LINE_LEN - 1)) begin
				ferr_n = 1'b1;
			end
			if (is_data_n && (seen_n < count_n || cs_n < 2'd2)) begin
				ferr_n = 1'b1;
			end
			status = ferr_n ? ihrp_pkg::STAT_FORMAT :
				(mism_n ? ihrp_pkg::STAT_MISMATCH : ihrp_pkg::STAT_OK);
			repl = pcnt_n;
			count_n = 8'd0;
			addr_n = 16'd0;
			sum_n = 8'd0;
			hi_n = 4'd0;
			seen_n = 8'd0;
			is_data_n = 1'b0;
			ferr_n = 1'b0;
			mism_n = 1'b0;
			pcnt_n = 4'd0;
			cs_n = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 8'd0;
			addr_q <= 16'd0;
			sum_q <= 8'd0;
			hi_q <= 4'd0;
			seen_q <= 8'd0;
			is_data_q <= 1'b0;
			ferr_q <= 1'b0;
			mism_q <= 1'b0;
			pcnt_q <= 4'd0;
			cs_q <= 2'd0;
			valid_q <= 1'b0;
		end else begin
			if (pop) begin
				count_q <= count_n;
				addr_q <= addr_n;
				sum_q <= sum_n;
				hi_q <= hi_n;
				seen_q <= seen_n;
				is_data_q <= is_data_n;
				ferr_q <= ferr_n;
				mism_q <= mism_n;
				pcnt_q <= pcnt_n;
				cs_q <= cs_n;
				valid_q <= 1'b1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ch_q <= ch;
			kept_q <= kept;
			last_q <= e.last;
			status_q <= status;
			repl_q <= repl;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata = {2'b00, repl_q, status_q, ch_q};
	assign m_tlast = last_q;
	assign m_tuser = kept_q;

endmodule

// ===== sv/intel_hex_record_patcher_unit.sv =====
// Channel  Direction  Handshake              Payload
// s_*      in         s_tvalid / s_tready    tdata char_in, tlast last_char
// m_*      out        m_tvalid / m_tready    tdata char_out, status, count; tuser char_kept
// cfg_*    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item per cycle unless m_* stalls; each item is queued, then registered for m_*.
// The back parser updates its line state once per item out of a two-entry queue.
// Reset (arst_n low) clears line state, queue and output valid; registers take defaults.
// A stalled m_* side fills the queue, then drops s_tready; cfg_ready is always high.
module intel_hex_record_patcher_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] char_in
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // [7:0] char_out, [9:8] line_status, [13:10] replaced_count
	output logic        m_tlast,
	output logic        m_tuser,  // [0] char_kept
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [55:0] cfg_data
);

	ihrp_pkg::cfg_t   cfg_q;
	ihrp_pkg::entry_t push_entry;
	ihrp_pkg::entry_t pop_entry;
	logic             push;
	logic             pop;
	logic             q_full;
	logic             q_not_empty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.patch_first <= 56'd0;
			cfg_q.patch_second <= 56'd0;
			cfg_q.window_base <= 16'h01E4;
			cfg_q.window_count <= 4'(ihrp_pkg::PATCH_SLOTS);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ihrp_pkg::CFG_PATCH_FIRST:  cfg_q.patch_first <= cfg_data;
				ihrp_pkg::CFG_PATCH_SECOND: cfg_q.patch_second <= cfg_data;
				ihrp_pkg::CFG_WINDOW_BASE:  cfg_q.window_base <= cfg_data[15:0];
				ihrp_pkg::CFG_WINDOW_COUNT: cfg_q.window_count <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	ihrp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	ihrp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.full       (q_full),
		.not_empty  (q_not_empty)
	);

	ihrp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.q_not_empty (q_not_empty),
		.e           (pop_entry),
		.pop         (pop),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast),
		.m_tuser     (m_tuser)
	);

	a_status_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[9:8] != 2'd0) |-> m_tlast)
		else $error("line status outside line end");

	a_count_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[13:10] != 4'd0) |-> m_tlast)
		else $error("replaced count outside line end");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[13:10] <= 4'(ihrp_pkg::PATCH_SLOTS) && m_tdata[9:8] != 2'd3))
		else $error("result field out of range");

endmodule

// ===== sim/intel_hex_record_patcher_unit_test.sv =====
module intel_hex_record_patcher_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;
	localparam logic [7:0] COLON = 8'h3A;
	localparam logic [7:0] REC_DATA = 8'h00;
	localparam logic [7:0] REC_EOF = 8'h01;
	localparam logic [7:0] REC_EXT_SEG = 8'h02;

	typedef struct {
		logic [7:0]        ch;
		bit                kept;
		bit                last;
		ihrp_pkg::status_t status;
		logic [3:0]        replaced;
	} out_char_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic        m_tlast;
	logic        m_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = 2'd0;
	logic [55:0] cfg_data = 56'd0;

	intel_hex_record_patcher_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// register copies
	logic [55:0] patch_lo = 56'd0;
	logic [55:0] patch_hi = 56'd0;
	logic [15:0] win_base = 16'd484;
	logic [3:0]  win_count = 4'd14;

	// per-line parse state
	int unsigned ln_pos = 0;
	logic [7:0]  ln_len = 8'd0;
	logic [15:0] ln_addr = 16'd0;
	logic [7:0]  ln_sum = 8'd0;
	logic [3:0]  ln_hi = 4'd0;
	logic [7:0]  ln_seen = 8'd0;
	bit          ln_data = 1'b0;
	bit          ln_bad = 1'b0;
	bit          ln_miss = 1'b0;
	logic [3:0]  ln_patched = 4'd0;
	logic [1:0]  ln_cs = 2'd0;

	logic [7:0] orig_pattern [0:13] = '{8'h01, 8'h23, 8'h45, 8'h67, 8'h89, 8'hAB, 8'hCD,
		8'hEF, 8'h11, 8'h33, 8'h55, 8'h77, 8'h99, 8'hBB};

	out_char_t  rewritten_q[$];
	logic [7:0] line_chars[$];
	int         mismatch_count = 0;
	int         result_idx = 0;
	int         cycle_count = 0;
	int         chars_sent = 0;
	int         tx_idle_pct = 11;
	int         rx_idle_pct = 73;

	function automatic logic [3:0] hex_value(input logic [7:0] c, output bit ok);
		ok = 1'b1;
		if (c >= "0" && c <= "9") return 4'(c - "0");
		if (c >= "A" && c <= "F") return 4'(c - "A" + 8'd10);
		if (c >= "a" && c <= "f") return 4'(c - "a" + 8'd10);
		ok = 1'b0;
		return 4'd0;
	endfunction

	function automatic logic [7:0] hex_digit(input logic [3:0] v, input bit lower);
		if (v < 4'd10) return "0" + 8'(v);
		return (lower ? "a" : "A") + 8'(v) - 8'd10;
	endfunction

	function automatic bit in_window(input logic [15:0] a, output int idx);
		int span;
		int off;
		span = (win_count > ihrp_pkg::PATCH_SLOTS) ? int'(ihrp_pkg::PATCH_SLOTS) :
			int'(win_count);
		idx = 0;
		if (a < win_base || int'(a) >= int'(win_base) + 2 * span) return 1'b0;
		off = int'(a) - int'(win_base);
		if (off % 2 != 0) return 1'b0;
		idx = off / 2;
		return 1'b1;
	endfunction

	function automatic logic [7:0] slot_byte(input int idx);
		if (idx < 7) return patch_lo[8*idx +: 8];
		return patch_hi[8*(idx-7) +: 8];
	endfunction

	function automatic void rewrite_char(input logic [7:0] c, input bit last);
		int unsigned p;
		int idx;
		bit ok;
		bit win;
		logic [3:0] v;
		logic [7:0] b;
		logic [7:0] r;
		logic [7:0] csum;
		out_char_t e;
		p = ln_pos;
		e.ch = c;
		e.kept = 1'b1;
		e.last = last;
		e.status = ihrp_pkg::STAT_OK;
		e.replaced = 4'd0;
		if (p == 0) begin
			if (c != COLON) ln_bad = 1'b1;
		end else if (p <= ihrp_pkg::HEADER_END) begin
			v = hex_value(c, ok);
			if (!ok) ln_bad = 1'b1;
			if (p % 2 == 1) begin
				ln_hi = v;
			end else begin
				b = {ln_hi, v};
				ln_sum += b;
				case (p)
					2: ln_len = b;
					4: ln_addr[15:8] = b;
					6: ln_addr[7:0] = b;
					default: begin
						if (!ln_bad && b == REC_DATA) ln_data = 1'b1;
					end
				endcase
			end
		end else if (ln_data) begin
			if (ln_seen < ln_len) begin
				win = in_window(ln_addr, idx);
				r = slot_byte(idx);
				v = hex_value(c, ok);
				if (!ok) ln_bad = 1'b1;
				if (p % 2 == 1) begin
					ln_hi = v;
					if (win) e.ch = hex_digit(r[7:4], 1'b0);
				end else begin
					b = {ln_hi, v};
					if (win) begin
						if (b != orig_pattern[idx]) ln_miss = 1'b1;
						e.ch = hex_digit(r[3:0], 1'b0);
						ln_sum += r;
						if (ln_patched != 4'd15) ln_patched++;
					end else begin
						ln_sum += b;
					end
					ln_seen++;
					ln_addr++;
				end
			end else if (ln_cs < 2'd2) begin
				csum = -ln_sum;
				e.ch = hex_digit((ln_cs == 2'd0) ? csum[7:4] : csum[3:0], 1'b0);
				ln_cs++;
			end else begin
				e.kept = 1'b0;
			end
		end
		if (ln_pos < ihrp_pkg::POS_MAX) ln_pos++;
		if (last) begin
			if (p + 1 < ihrp_pkg::MIN_LINE_LEN) ln_bad = 1'b1;
			if (ln_data && (ln_seen < ln_len || ln_cs < 2'd2)) ln_bad = 1'b1;
			e.status = ln_bad ? ihrp_pkg::STAT_FORMAT :
				(ln_miss ? ihrp_pkg::STAT_MISMATCH : ihrp_pkg::STAT_OK);
			e.replaced = ln_patched;
			ln_pos = 0;
			ln_len = 8'd0;
			ln_addr = 16'd0;
			ln_sum = 8'd0;
			ln_hi = 4'd0;
			ln_seen = 8'd0;
			ln_data = 1'b0;
			ln_bad = 1'b0;
			ln_miss = 1'b0;
			ln_patched = 4'd0;
			ln_cs = 2'd0;
		end
		rewritten_q.push_back(e);
	endfunction

	task automatic flag_mismatch(input string what, input longint got, input longint want);
		mismatch_count++;
		$display("%0t result %0d: %s is %0h, expected %0h",
			$time, result_idx, what, got, want);
	endtask

	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
	end

	always @(posedge clk) begin : check_results
		out_char_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (rewritten_q.size() == 0) begin
				flag_mismatch("unexpected item", m_tdata, 0);
			end else begin
				want = rewritten_q.pop_front();
				if (m_tdata[7:0] !== want.ch) flag_mismatch("char_out", m_tdata[7:0], want.ch);
				if (m_tuser !== want.kept) flag_mismatch("char_kept", m_tuser, want.kept);
				if (m_tlast !== want.last) flag_mismatch("line_end", m_tlast, want.last);
				if (m_tdata[9:8] !== want.status)
					flag_mismatch("line_status", m_tdata[9:8], want.status);
				if (m_tdata[13:10] !== want.replaced)
					flag_mismatch("replaced_count", m_tdata[13:10], want.replaced);
			end
			result_idx++;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("intel_hex_record_patcher_unit_test: done, errors");
			$finish;
		end
	end

	task automatic send_char(input logic [7:0] c, input bit last);
		if ($urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata <= c;
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		rewrite_char(c, last);
		chars_sent++;
	endtask

	task automatic send_line();
		foreach (line_chars[i]) send_char(line_chars[i], i == line_chars.size() - 1);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (rewritten_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input ihrp_pkg::cfg_index_t idx, input logic [55:0] value);
		logic [55:0] data;
		data = 56'({$urandom, $urandom});
		case (idx)
			ihrp_pkg::CFG_WINDOW_BASE: data[15:0] = value[15:0];
			ihrp_pkg::CFG_WINDOW_COUNT: data[3:0] = value[3:0];
			default: data = value;
		endcase
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			ihrp_pkg::CFG_PATCH_FIRST: patch_lo = data;
			ihrp_pkg::CFG_PATCH_SECOND: patch_hi = data;
			ihrp_pkg::CFG_WINDOW_BASE: win_base = data[15:0];
			ihrp_pkg::CFG_WINDOW_COUNT: win_count = data[3:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_config(input logic [55:0] first, input logic [55:0] second,
		input logic [15:0] base, input logic [3:0] count);
		wait_drained();
		write_reg(ihrp_pkg::CFG_PATCH_FIRST, first);
		write_reg(ihrp_pkg::CFG_PATCH_SECOND, second);
		write_reg(ihrp_pkg::CFG_WINDOW_BASE, {40'd0, base});
		write_reg(ihrp_pkg::CFG_WINDOW_COUNT, {52'd0, count});
	endtask

	task automatic put_hex(input logic [7:0] b);
		line_chars.push_back(hex_digit(b[7:4], 1'($urandom_range(0, 1))));
		line_chars.push_back(hex_digit(b[3:0], 1'($urandom_range(0, 1))));
	endtask

	task automatic build_record(input int len, input logic [15:0] addr, input logic [7:0] rtype,
		input int match_pct);
		logic [7:0] sum;
		logic [7:0] b;
		int idx;
		line_chars.delete();
		line_chars.push_back(COLON);
		sum = 8'(len) + addr[15:8] + addr[7:0] + rtype;
		put_hex(8'(len));
		put_hex(addr[15:8]);
		put_hex(addr[7:0]);
		put_hex(rtype);
		for (int k = 0; k < len; k++) begin
			if (in_window(addr + 16'(k), idx) && $urandom_range(0, 99) < match_pct)
				b = orig_pattern[idx];
			else
				b = 8'($urandom);
			sum += b;
			put_hex(b);
		end
		put_hex(-sum);
	endtask

	task automatic test_default_window();
		build_record(28, 16'h01E4, REC_DATA, 100);
		send_line();
		build_record(30, 16'h01E3, REC_DATA, 0);
		send_line();
		build_record(0, 16'h0000, REC_EOF, 0);
		send_line();
	endtask

	task automatic test_register_extremes();
		set_config({56{1'b1}}, 56'd0, 16'hFFF8, 4'd15);
		build_record(20, 16'hFFF6, REC_DATA, 100);
		send_line();
		set_config(56'd0, {56{1'b1}}, 16'h0000, 4'd0);
		build_record(8, 16'h0000, REC_DATA, 100);
		send_line();
		set_config(56'({$urandom, $urandom}), 56'({$urandom, $urandom}), 16'h0000, 4'd1);
		build_record(4, 16'h0000, REC_DATA, 100);
		send_line();
		set_config(56'({$urandom, $urandom}), 56'({$urandom, $urandom}), 16'hFFFF, 4'd14);
		build_record(4, 16'hFFFE, REC_DATA, 50);
		send_line();
	endtask

	task automatic test_malformed_lines();
		set_config(56'({$urandom, $urandom}), 56'({$urandom, $urandom}), 16'h0040, 4'd6);
		// no colon
		build_record(4, 16'h0040, REC_DATA, 100);
		line_chars[0] = ";";
		send_line();
		// colon alone, then a nine-character line
		line_chars.delete();
		line_chars.push_back(COLON);
		send_line();
		build_record(0, 16'h0000, REC_EOF, 0);
		void'(line_chars.pop_back());
		void'(line_chars.pop_back());
		send_line();
		build_record(0, 16'h0000, REC_EOF, 0);
		send_line();
		build_record(6, 16'h0040, REC_EXT_SEG, 100);
		send_line();
		// bad digit in count, in type, in data
		build_record(4, 16'h0040, REC_DATA, 100);
		line_chars[2] = "G";
		send_line();
		build_record(4, 16'h0040, REC_DATA, 100);
		line_chars[8] = "z";
		send_line();
		build_record(6, 16'h0040, REC_DATA, 100);
		line_chars[12] = "x";
		send_line();
		// cut inside data, cut inside checksum
		build_record(6, 16'h003F, REC_DATA, 100);
		while (line_chars.size() > 14) void'(line_chars.pop_back());
		send_line();
		build_record(6, 16'h0040, REC_DATA, 100);
		void'(line_chars.pop_back());
		send_line();
		// drop characters past the checksum
		build_record(5, 16'h0041, REC_DATA, 100);
		line_chars.push_back(8'h00);
		line_chars.push_back(8'hFF);
		line_chars.push_back(COLON);
		send_line();
		line_chars.delete();
		repeat (16) line_chars.push_back(8'($urandom_range(128, 255)));
		line_chars.push_back(8'h00);
		send_line();
	endtask

	task automatic test_pause_mid_line();
		build_record(10, win_base, REC_DATA, 100);
		for (int i = 0; i < line_chars.size(); i++) begin
			if (i == 12) wait_drained();
			send_char(line_chars[i], i == line_chars.size() - 1);
		end
	endtask

	task automatic random_line();
		int len;
		int kind;
		int cut;
		logic [15:0] addr;
		logic [7:0] rtype;
		len = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 16) : $urandom_range(17, 40);
		if ($urandom_range(0, 99) < 70)
			addr = win_base - 16'($urandom_range(0, len));
		else
			addr = 16'($urandom);
		rtype = ($urandom_range(0, 99) < 85) ? REC_DATA : 8'($urandom);
		build_record(len, addr, rtype, 50);
		kind = $urandom_range(0, 99);
		if (kind < 8) begin
			cut = $urandom_range(1, line_chars.size());
			while (line_chars.size() > cut) void'(line_chars.pop_back());
		end else if (kind < 16) begin
			line_chars[$urandom_range(0, line_chars.size() - 1)] = 8'($urandom);
		end else if (kind < 20) begin
			line_chars[0] = 8'($urandom);
		end else if (kind < 35) begin
			repeat ($urandom_range(1, 6)) line_chars.push_back(8'($urandom));
		end
		send_line();
	endtask

	task automatic test_random_phase(input int tx_pct, input int rx_pct, input int nchars);
		int start;
		set_config(56'({$urandom, $urandom}), 56'({$urandom, $urandom}), 16'($urandom),
			4'($urandom_range(0, 15)));
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		start = chars_sent;
		while (chars_sent - start < nchars) random_line();
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_window();
		test_register_extremes();
		test_malformed_lines();
		test_pause_mid_line();
		test_random_phase(11, 73, 25);
		test_random_phase(73, 11, 25);
		test_random_phase(0, 0, 25);
		wait_drained();
		repeat (16) @(posedge clk);
		if (mismatch_count == 0 && rewritten_q.size() == 0) begin
			$display("intel_hex_record_patcher_unit_test: done, clean");
		end else begin
			$display("intel_hex_record_patcher_unit_test: done, errors");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/ihrp_pkg.sv
sv/ihrp_front.sv
sv/ihrp_queue.sv
sv/ihrp_back.sv
sv/intel_hex_record_patcher_unit.sv
sim/intel_hex_record_patcher_unit_test.sv
